// ===== rtl/dcr_pkg.sv =====
// ----------------------------------------------------------------------------
// Decimal coordinate rescaler package
// Shared types, error codes and decimal helper functions.
// ----------------------------------------------------------------------------
package dcr_pkg;

   localparam int NumCoord = 6;
   localparam int NumHoriz = 4;

   // Error codes of a result beat.
   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_ZERO   = 2'd1;
   localparam logic [1:0] ERR_NONSTD = 2'd2;
   localparam logic [1:0] ERR_EXP    = 2'd3;

   typedef logic signed [31:0] coord_type;
   typedef logic signed [3:0]  pow_type;
   typedef logic [26:0]        factor_type;

   typedef struct packed {
      logic [1:0] err;
      pow_type    pow;
   } norm_type;

   // Group results handed from the front end to the multiplier lanes.
   typedef struct packed {
      logic [1:0] err;
      pow_type    hn;
      pow_type    vn;
      factor_type fac_h;
      factor_type fac_v;
   } meta_type;

   // Normalises a scale word and returns its decimal power or an error.
   function automatic norm_type normalize(input logic signed [15:0] s,
                                          input logic strict);
      logic signed [16:0] sx;
      logic [16:0]        mag;
      logic [2:0]         k;
      norm_type           r;
      sx    = 17'(s);
      mag   = s[15] ? 17'(-sx) : 17'(sx);
      r.err = ERR_NONE;
      if (mag >= 17'd10000)
         k = 3'd4;
      else if (mag >= 17'd1000)
         k = 3'd3;
      else if (mag >= 17'd100)
         k = 3'd2;
      else if (mag >= 17'd10)
         k = 3'd1;
      else
         k = 3'd0;
      if (s == 16'sd0) begin
         if (strict)
            r.err = ERR_ZERO;
      end else if (mag < 17'd10 && s != 16'sd1) begin
         if (strict)
            r.err = ERR_NONSTD;
         else if (mag >= 17'd5)
            r.err = ERR_EXP;
         else
            k = mag[2:0];
      end
      r.pow = s[15] ? -pow_type'({1'b0, k}) : pow_type'({1'b0, k});
      return r;
   endfunction

   // Number of further decades the value survives inside the 16-bit range.
   function automatic logic [3:0] fit_steps(input coord_type c);
      logic [3:0] e;
      if (c == 32'sd0)
         e = 4'd8;
      else if (c >= -32'sd3 && c <= 32'sd3)
         e = 4'd3;
      else if (c >= -32'sd32 && c <= 32'sd32)
         e = 4'd2;
      else if (c >= -32'sd327 && c <= 32'sd327)
         e = 4'd1;
      else
         e = 4'd0;
      return e;
   endfunction

   // Lowest decimal power allowed for one coordinate.
   function automatic pow_type lowest(input coord_type c, input pow_type p0,
                                      input pow_type lp);
      logic signed [5:0] q;
      q = 6'(p0) - 6'sd1 - $signed({2'b00, fit_steps(c)});
      if (q < 6'(lp))
         q = 6'(lp);
      if (p0 <= lp)
         q = 6'(p0);
      return q[3:0];
   endfunction

   function automatic factor_type dec_factor(input logic [3:0] d);
      factor_type f;
      unique case (d)
         4'd0:    f = 27'd1;
         4'd1:    f = 27'd10;
         4'd2:    f = 27'd100;
         4'd3:    f = 27'd1000;
         4'd4:    f = 27'd10000;
         4'd5:    f = 27'd100000;
         4'd6:    f = 27'd1000000;
         4'd7:    f = 27'd10000000;
         4'd8:    f = 27'd100000000;
         default: f = 27'd0;
      endcase
      return f;
   endfunction

   // Scale word for a decimal power: plus or minus ten to its magnitude.
   function automatic logic signed [14:0] pow_scale(input pow_type p);
      logic [3:0]         m;
      logic signed [14:0] v;
      m = p[3] ? 4'(-p) : 4'(p);
      v = $signed(15'(dec_factor(m)));
      return p[3] ? -v : v;
   endfunction

endpackage

// ===== rtl/dcr_if.sv =====
// ----------------------------------------------------------------------------
// Decimal coordinate rescaler channels
// Request and response channels with valid, ready and payload.
// ----------------------------------------------------------------------------
interface dcr_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] horizontal_scale_in;
   logic signed [15:0] vertical_scale_in;
   logic signed [31:0] source_x_in;
   logic signed [31:0] source_y_in;
   logic signed [31:0] receiver_x_in;
   logic signed [31:0] receiver_y_in;
   logic signed [31:0] source_depth_in;
   logic signed [31:0] receiver_elev_in;

   modport source (output valid, horizontal_scale_in, vertical_scale_in, source_x_in,
                   source_y_in, receiver_x_in, receiver_y_in, source_depth_in,
                   receiver_elev_in, input ready);
   modport sink (input valid, horizontal_scale_in, vertical_scale_in, source_x_in,
                 source_y_in, receiver_x_in, receiver_y_in, source_depth_in,
                 receiver_elev_in, output ready);
endinterface

interface dcr_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [14:0] horizontal_scale_out;
   logic signed [14:0] vertical_scale_out;
   logic signed [31:0] source_x_out;
   logic signed [31:0] source_y_out;
   logic signed [31:0] receiver_x_out;
   logic signed [31:0] receiver_y_out;
   logic signed [31:0] source_depth_out;
   logic signed [31:0] receiver_elev_out;
   logic               truncated;
   logic [1:0]         error_code;

   modport source (output valid, horizontal_scale_out, vertical_scale_out, source_x_out,
                   source_y_out, receiver_x_out, receiver_y_out, source_depth_out,
                   receiver_elev_out, truncated, error_code, input ready);
   modport sink (input valid, horizontal_scale_out, vertical_scale_out, source_x_out,
                 source_y_out, receiver_x_out, receiver_y_out, source_depth_out,
                 receiver_elev_out, truncated, error_code, output ready);
endinterface

// ===== rtl/dcr_front.sv =====
// ----------------------------------------------------------------------------
// Decimal coordinate rescaler front end
// Scale normalisation, per-coordinate power search and group maximum.
// ----------------------------------------------------------------------------
module dcr_front
   import dcr_pkg::*;
(
   input  logic               clock,
   input  logic               en,
   input  logic signed [15:0] h_scale,
   input  logic signed [15:0] v_scale,
   input  coord_type          coords [NumCoord],
   input  logic signed [15:0] desired,
   input  logic               strict,
   output coord_type          coords_out [NumCoord],
   output meta_type           meta_out
);

   norm_type  hn_norm, vn_norm, dn_norm;
   pow_type   lp;
   logic [1:0] err_in;
   coord_type c1_ff [NumCoord];
   pow_type   p1_in [NumCoord];
   pow_type   p1_ff [NumCoord];
   pow_type   hp1_ff, vp1_ff;
   logic [1:0] err1_ff;
   pow_type   hmax, vmax;
   logic signed [4:0] dh, dv;
   meta_type  meta2_in, meta2_ff;
   coord_type c2_ff [NumCoord];

   // Normalise all three scale words; first failing check wins.
   always_comb begin
      hn_norm = normalize(h_scale, strict);
      vn_norm = normalize(v_scale, strict);
      dn_norm = normalize(desired, 1'b1);
      lp      = dn_norm.pow;
      if (hn_norm.err != ERR_NONE)
         err_in = hn_norm.err;
      else if (vn_norm.err != ERR_NONE)
         err_in = vn_norm.err;
      else
         err_in = dn_norm.err;
   end

   // Lowest power each coordinate allows.
   always_comb begin
      for (int i = 0; i < NumCoord; i++) begin
         if (i < NumHoriz)
            p1_in[i] = lowest(coords[i], hn_norm.pow, lp);
         else
            p1_in[i] = lowest(coords[i], vn_norm.pow, lp);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c1_ff   <= coords;
         p1_ff   <= p1_in;
         hp1_ff  <= hn_norm.pow;
         vp1_ff  <= vn_norm.pow;
         err1_ff <= err_in;
      end
   end

   // Group maximum and the decimal factor towards it.
   always_comb begin
      hmax = p1_ff[0];
      for (int i = 1; i < NumHoriz; i++)
         if (p1_ff[i] > hmax)
            hmax = p1_ff[i];
      vmax = p1_ff[NumHoriz];
      for (int i = NumHoriz + 1; i < NumCoord; i++)
         if (p1_ff[i] > vmax)
            vmax = p1_ff[i];
      dh             = 5'(hp1_ff) - 5'(hmax);
      dv             = 5'(vp1_ff) - 5'(vmax);
      meta2_in.err   = err1_ff;
      meta2_in.hn    = hmax;
      meta2_in.vn    = vmax;
      meta2_in.fac_h = dec_factor(dh[3:0]);
      meta2_in.fac_v = dec_factor(dv[3:0]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c2_ff    <= c1_ff;
         meta2_ff <= meta2_in;
      end
   end

   assign coords_out = c2_ff;
   assign meta_out   = meta2_ff;

endmodule

// ===== rtl/dcr_lane.sv =====
// ----------------------------------------------------------------------------
// Decimal coordinate rescaler lane
// Multiplies one coordinate by its decimal factor and saturates to 32 bits.
// ----------------------------------------------------------------------------
module dcr_lane
   import dcr_pkg::*;
(
   input  logic       clock,
   input  logic       en,
   input  coord_type  c,
   input  factor_type factor,
   input  logic       clear,
   output coord_type  value,
   output logic       trunc
);

   localparam logic signed [59:0] MaxVal = 60'sd2147483647;
   localparam logic signed [59:0] MinVal = -60'sd2147483648;

   logic signed [59:0] prod_in, prod_ff;
   coord_type          val_in, val_ff;
   logic               trunc_in, trunc_ff;

   // Product stage.
   assign prod_in = c * $signed({1'b0, factor});

   always_ff @(posedge clock) begin
      if (en)
         prod_ff <= prod_in;
   end

   // Saturation stage; an error beat clears the lane.
   always_comb begin
      trunc_in = 1'b0;
      if (prod_ff > MaxVal) begin
         val_in   = 32'sh7FFFFFFF;
         trunc_in = 1'b1;
      end else if (prod_ff < MinVal) begin
         val_in   = 32'sh80000000;
         trunc_in = 1'b1;
      end else begin
         val_in = prod_ff[31:0];
      end
      if (clear) begin
         val_in   = 32'sd0;
         trunc_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         val_ff   <= val_in;
         trunc_ff <= trunc_in;
      end
   end

   assign value = val_ff;
   assign trunc = trunc_ff;

endmodule

// ===== rtl/decimal_coordinate_rescaler.sv =====
// ----------------------------------------------------------------------------
// Decimal coordinate rescaler
// Throughput: one beat per cycle through a four-stage pipeline that stalls
// as a whole while the response register is held.
// Reset clears the stage valid bits, desired_scale to 1 and strict_mode to 0.
// ----------------------------------------------------------------------------
module decimal_coordinate_rescaler
   import dcr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   dcr_req_if.sink     req_bus,
   dcr_rsp_if.source   rsp_bus,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   localparam logic CSR_DESIRED = 1'b0;
   localparam logic CSR_STRICT  = 1'b1;

   logic signed [15:0] desired_ff;
   logic               strict_ff;
   logic [3:0]         valid_ff, valid_in;
   logic               en;
   coord_type          coords [NumCoord];
   coord_type          coords2 [NumCoord];
   coord_type          results [NumCoord];
   logic [NumCoord-1:0] truncs;
   meta_type           meta2;
   logic [1:0]         err3_ff, err4_ff;
   pow_type            hn3_ff, vn3_ff;
   logic signed [14:0] hscale_ff, vscale_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         desired_ff <= 16'sd1;
         strict_ff  <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DESIRED: desired_ff <= csr_wdata;
            CSR_STRICT:  strict_ff  <= csr_wdata[0];
            default:     strict_ff  <= strict_ff;
         endcase
      end
   end

   // Pipeline advances unless the response beat is held.
   assign en       = !valid_ff[3] || rsp_bus.ready;
   assign valid_in = {valid_ff[2:0], req_bus.valid};

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= '0;
      else if (en)
         valid_ff <= valid_in;
   end

   assign req_bus.ready = en;

   assign coords[0] = req_bus.source_x_in;
   assign coords[1] = req_bus.source_y_in;
   assign coords[2] = req_bus.receiver_x_in;
   assign coords[3] = req_bus.receiver_y_in;
   assign coords[4] = req_bus.source_depth_in;
   assign coords[5] = req_bus.receiver_elev_in;

   dcr_front u_front (
      .clock      (clock),
      .en         (en),
      .h_scale    (req_bus.horizontal_scale_in),
      .v_scale    (req_bus.vertical_scale_in),
      .coords     (coords),
      .desired    (desired_ff),
      .strict     (strict_ff),
      .coords_out (coords2),
      .meta_out   (meta2)
   );

   // Group powers and error code follow the lanes.
   always_ff @(posedge clock) begin
      if (en) begin
         err3_ff   <= meta2.err;
         hn3_ff    <= meta2.hn;
         vn3_ff    <= meta2.vn;
         err4_ff   <= err3_ff;
         hscale_ff <= (err3_ff != ERR_NONE) ? 15'sd0 : pow_scale(hn3_ff);
         vscale_ff <= (err3_ff != ERR_NONE) ? 15'sd0 : pow_scale(vn3_ff);
      end
   end

   for (genvar i = 0; i < NumCoord; i++) begin : g_lane
      dcr_lane u_lane (
         .clock  (clock),
         .en     (en),
         .c      (coords2[i]),
         .factor ((i < NumHoriz) ? meta2.fac_h : meta2.fac_v),
         .clear  (err3_ff != ERR_NONE),
         .value  (results[i]),
         .trunc  (truncs[i])
      );
   end

   // Response beat.
   assign rsp_bus.valid                = valid_ff[3];
   assign rsp_bus.horizontal_scale_out = hscale_ff;
   assign rsp_bus.vertical_scale_out   = vscale_ff;
   assign rsp_bus.source_x_out         = results[0];
   assign rsp_bus.source_y_out         = results[1];
   assign rsp_bus.receiver_x_out       = results[2];
   assign rsp_bus.receiver_y_out       = results[3];
   assign rsp_bus.source_depth_out     = results[4];
   assign rsp_bus.receiver_elev_out    = results[5];
   assign rsp_bus.truncated            = |truncs;
   assign rsp_bus.error_code           = err4_ff;

endmodule
